>>> sv/assert_macros.svh
// Assertion shorthands shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, held off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> sv/mer_pkg.sv
package mer_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int COORD_BITS  = 12;

  localparam int PIX_W  = COORD_BITS + 1;
  localparam int STEP_W = RADIUS_BITS + 1;
  localparam int SQ_W   = 2 * RADIUS_BITS;
  localparam int MA_W   = 2 * RADIUS_BITS;
  localparam int MB_W   = 2 * RADIUS_BITS + 4;
  localparam int PROD_W = MA_W + MB_W;
  localparam int PQ_W   = 3 * RADIUS_BITS + 1;
  localparam int DEC_W  = 4 * RADIUS_BITS + 8;
  localparam int OFS_W  = (PIX_W > STEP_W + 1) ? PIX_W : STEP_W + 1;

  localparam int BEATS = 4;
  localparam int IDX_W = $clog2(BEATS);

  // Item opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_START,
    DP_SQ_MAJOR,
    DP_SQ_MINOR,
    DP_A2B,
    DP_INIT_D,
    DP_T_T,
    DP_T_BT,
    DP_T_U,
    DP_T_AU,
    DP_T_AB,
    DP_T_FIN,
    DP_MOVE,
    DP_MUL_P,
    DP_MUL_Q,
    DP_UPD_D,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic             region2;
    logic             vertex;
    logic [IDX_W-1:0] index;
    logic             last;
    logic             done;
  } dp_cmd_t;

  typedef struct packed {
    logic cond;
    logic y_gt1;
    logic out_free;
  } dp_status_t;

endpackage

>>> sv/mer_in_if.sv
interface mer_in_if import mer_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [RADIUS_BITS-1:0] radius_x;
  logic        [RADIUS_BITS-1:0] radius_y;

  modport source (output valid, op, center_x, center_y, radius_x, radius_y, input ready);
  modport sink (input valid, op, center_x, center_y, radius_x, radius_y, output ready);
endinterface

>>> sv/mer_out_if.sv
interface mer_out_if import mer_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic                    last_of_run;
  logic                    curve_done;

  modport source (output valid, pixel_x, pixel_y, last_of_run, curve_done, input ready);
  modport sink (input valid, pixel_x, pixel_y, last_of_run, curve_done, output ready);
endinterface

>>> sv/mer_datapath.sv
`include "assert_macros.svh"

module mer_datapath import mer_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  dp_cmd_t                        cmd,
  output dp_status_t                     status,
  input  logic signed [COORD_BITS-1:0]   center_x,
  input  logic signed [COORD_BITS-1:0]   center_y,
  input  logic        [RADIUS_BITS-1:0]  radius_x,
  input  logic        [RADIUS_BITS-1:0]  radius_y,
  input  logic                           pixel_ready,
  output logic                           pixel_valid,
  output logic signed [PIX_W-1:0]        pixel_x,
  output logic signed [PIX_W-1:0]        pixel_y,
  output logic                           last_of_run,
  output logic                           curve_done
);

  logic signed [COORD_BITS-1:0]  origin_x;
  logic signed [COORD_BITS-1:0]  origin_y;
  logic        [RADIUS_BITS-1:0] major;
  logic        [RADIUS_BITS-1:0] minor;
  logic                          swapped;
  logic [SQ_W-1:0]               a2;
  logic [SQ_W-1:0]               b2;
  logic [STEP_W-1:0]             x;
  logic [STEP_W-1:0]             y;
  logic [DEC_W-1:0]              d;
  logic [PQ_W-1:0]               p;
  logic [PQ_W-1:0]               q;
  logic                          moved;
  logic [PROD_W-1:0]             prod;

  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [STEP_W:0]   t;
  logic [STEP_W-1:0] u;
  logic [DEC_W-1:0]  prod_d;
  logic [DEC_W-1:0]  p_d;
  logic [DEC_W-1:0]  a2_d;
  logic [DEC_W-1:0]  b2_d;
  logic              d_neg;
  logic              d_pos;

  logic [STEP_W-1:0] h_mag;
  logic [STEP_W-1:0] v_mag;
  logic              neg_h;
  logic              neg_v;
  logic [OFS_W-1:0]  h_ofs;
  logic [OFS_W-1:0]  v_ofs;
  logic [OFS_W-1:0]  sum_x;
  logic [OFS_W-1:0]  sum_y;

  assign t      = {x, 1'b1};
  assign u      = y - STEP_W'(1);
  assign prod_d = DEC_W'(prod);
  assign p_d    = DEC_W'(p);
  assign a2_d   = DEC_W'(a2);
  assign b2_d   = DEC_W'(b2);
  assign d_neg  = d[DEC_W-1];
  assign d_pos  = !d_neg && (d != '0);

  assign status.cond     = p < q;
  assign status.y_gt1    = y > STEP_W'(1);
  assign status.out_free = !pixel_valid || pixel_ready;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      DP_SQ_MAJOR: begin mul_a = MA_W'(major);  mul_b = MB_W'(major); end
      DP_SQ_MINOR: begin mul_a = MA_W'(minor);  mul_b = MB_W'(minor); end
      DP_A2B:      begin mul_a = a2;            mul_b = MB_W'(minor); end
      DP_MUL_P:    begin mul_a = b2;            mul_b = MB_W'(x);     end
      DP_MUL_Q:    begin mul_a = a2;            mul_b = MB_W'(y);     end
      DP_T_T:      begin mul_a = MA_W'(t);      mul_b = MB_W'(t);     end
      DP_T_BT:     begin mul_a = b2;            mul_b = prod[MB_W-1:0]; end
      DP_T_U:      begin mul_a = MA_W'(u);      mul_b = MB_W'(u);     end
      DP_T_AU:     begin mul_a = a2;            mul_b = prod[MB_W-1:0]; end
      DP_T_AB:     begin mul_a = a2;            mul_b = MB_W'(b2);    end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Walk state and decision variable
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      major    <= '0;
      minor    <= '0;
      swapped  <= 1'b0;
      a2       <= '0;
      b2       <= '0;
      x        <= '0;
      y        <= '0;
      d        <= '0;
      p        <= '0;
      q        <= '0;
      moved    <= 1'b0;
    end else begin
      unique case (cmd.op)
        DP_START: begin
          origin_x <= center_x;
          origin_y <= center_y;
          swapped  <= radius_y > radius_x;
          major    <= (radius_y > radius_x) ? radius_y : radius_x;
          minor    <= (radius_y > radius_x) ? radius_x : radius_y;
          x        <= '0;
          y        <= STEP_W'((radius_y > radius_x) ? radius_x : radius_y);
        end
        DP_SQ_MINOR: a2 <= prod[SQ_W-1:0];
        DP_A2B:      b2 <= prod[SQ_W-1:0];
        DP_INIT_D: begin
          p <= '0;
          q <= prod[PQ_W-1:0];
          d <= (b2_d << 2) - (prod_d << 2) + a2_d;
        end
        DP_T_U:   d <= prod_d;
        DP_T_AB:  d <= d + (prod_d << 2);
        DP_T_FIN: d <= d - (prod_d << 2);
        DP_MOVE: begin
          if (!cmd.region2) begin
            x     <= x + STEP_W'(1);
            moved <= !d_neg;
            if (!d_neg) begin
              y <= y - STEP_W'(1);
            end
          end else begin
            y     <= y - STEP_W'(1);
            moved <= !d_pos;
            if (!d_pos) begin
              x <= x + STEP_W'(1);
            end
          end
        end
        DP_MUL_Q: p <= prod[PQ_W-1:0];
        DP_UPD_D: begin
          q <= prod[PQ_W-1:0];
          if (!cmd.region2) begin
            d <= d + (p_d << 3) + (b2_d << 2) - (moved ? (prod_d << 3) : '0);
          end else begin
            d <= d + (a2_d << 2) - (prod_d << 3) + (moved ? (p_d << 3) : '0);
          end
        end
        default: ;
      endcase
    end
  end

  // Offset of the current beat: vertices on start, mirrored points on a step
  always_comb begin
    if (cmd.vertex) begin
      h_mag = cmd.index[1] ? STEP_W'(swapped ? minor : major) : '0;
      v_mag = cmd.index[1] ? '0 : STEP_W'(swapped ? major : minor);
      neg_h = cmd.index[0];
      neg_v = cmd.index[0];
    end else begin
      h_mag = swapped ? y : x;
      v_mag = swapped ? x : y;
      neg_h = cmd.index[1];
      neg_v = cmd.index[0];
    end
    h_ofs = neg_h ? -OFS_W'(h_mag) : OFS_W'(h_mag);
    v_ofs = neg_v ? -OFS_W'(v_mag) : OFS_W'(v_mag);
    sum_x = OFS_W'(origin_x) + h_ofs;
    sum_y = OFS_W'(origin_y) + v_ofs;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (cmd.op == DP_EMIT) begin
      pixel_valid <= 1'b1;
    end else if (pixel_ready) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT) begin
      pixel_x     <= sum_x[PIX_W-1:0];
      pixel_y     <= sum_y[PIX_W-1:0];
      last_of_run <= cmd.last;
      curve_done  <= cmd.done;
    end
  end

  `ASSERT_CLK(a_emit_into_free, (cmd.op == DP_EMIT) |-> (!pixel_valid || pixel_ready), "beat loaded over a waiting beat")
  `ASSERT_NEVER(a_y_bound, y > STEP_W'(minor), "walk y above minor radius")

endmodule

>>> sv/mer_ctrl.sv
`include "assert_macros.svh"

module mer_ctrl import mer_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_op,
  output logic       item_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_WAIT,
    ST_SQ_MAJOR,
    ST_SQ_MINOR,
    ST_A2B,
    ST_INIT_D,
    ST_T_T,
    ST_T_BT,
    ST_T_U,
    ST_T_AU,
    ST_T_AB,
    ST_T_FIN,
    ST_MOVE,
    ST_MUL_P,
    ST_MUL_Q,
    ST_UPD_D,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {PH_IDLE, PH_R1, PH_R2, PH_DONE} phase_t;

  state_t           state;
  phase_t           phase;
  logic             vertex;
  logic [IDX_W-1:0] beat;
  logic             accept;
  logic             more;
  logic             last;

  assign item_ready = (state == ST_WAIT);
  assign accept     = item_valid && item_ready;
  assign more       = (phase == PH_R1) ? (status.cond || status.y_gt1) : status.y_gt1;
  assign last       = (beat == IDX_W'(BEATS - 1));

  always_comb begin
    cmd.op      = DP_NONE;
    cmd.region2 = (phase == PH_R2);
    cmd.vertex  = vertex;
    cmd.index   = beat;
    cmd.last    = last;
    cmd.done    = !more;
    unique case (state)
      ST_WAIT:     if (accept && item_op == OP_START) cmd.op = DP_START;
      ST_SQ_MAJOR: cmd.op = DP_SQ_MAJOR;
      ST_SQ_MINOR: cmd.op = DP_SQ_MINOR;
      ST_A2B:      cmd.op = DP_A2B;
      ST_INIT_D:   cmd.op = DP_INIT_D;
      ST_T_T:      cmd.op = DP_T_T;
      ST_T_BT:     cmd.op = DP_T_BT;
      ST_T_U:      cmd.op = DP_T_U;
      ST_T_AU:     cmd.op = DP_T_AU;
      ST_T_AB:     cmd.op = DP_T_AB;
      ST_T_FIN:    cmd.op = DP_T_FIN;
      ST_MOVE:     cmd.op = DP_MOVE;
      ST_MUL_P:    cmd.op = DP_MUL_P;
      ST_MUL_Q:    cmd.op = DP_MUL_Q;
      ST_UPD_D:    cmd.op = DP_UPD_D;
      ST_EMIT:     if (status.out_free) cmd.op = DP_EMIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_WAIT;
      phase  <= PH_IDLE;
      vertex <= 1'b0;
      beat   <= '0;
    end else begin
      unique case (state)
        ST_WAIT: begin
          if (accept) begin
            if (item_op == OP_START) begin
              phase  <= PH_R1;
              vertex <= 1'b1;
              state  <= ST_SQ_MAJOR;
            end else begin
              vertex <= 1'b0;
              priority if (phase == PH_R1 && status.cond) begin
                state <= ST_MOVE;
              end else if ((phase == PH_R1 || phase == PH_R2) && !status.y_gt1) begin
                phase <= PH_DONE;
              end else if (phase == PH_R1) begin
                phase <= PH_R2;
                state <= ST_T_T;
              end else if (phase == PH_R2) begin
                state <= ST_MOVE;
              end else begin
                state <= ST_WAIT;
              end
            end
          end
        end
        ST_SQ_MAJOR: state <= ST_SQ_MINOR;
        ST_SQ_MINOR: state <= ST_A2B;
        ST_A2B:      state <= ST_INIT_D;
        ST_INIT_D: begin
          beat  <= '0;
          state <= ST_EMIT;
        end
        ST_T_T:   state <= ST_T_BT;
        ST_T_BT:  state <= ST_T_U;
        ST_T_U:   state <= ST_T_AU;
        ST_T_AU:  state <= ST_T_AB;
        ST_T_AB:  state <= ST_T_FIN;
        ST_T_FIN: state <= ST_MOVE;
        ST_MOVE:  state <= ST_MUL_P;
        ST_MUL_P: state <= ST_MUL_Q;
        ST_MUL_Q: state <= ST_UPD_D;
        ST_UPD_D: begin
          beat  <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (status.out_free) begin
            beat <= beat + IDX_W'(1);
            if (last) begin
              state <= ST_WAIT;
              if (!more) begin
                phase <= PH_DONE;
              end
            end
          end
        end
      endcase
    end
  end

  `ASSERT_CLK(a_start_latency, (accept && item_op == OP_START) |-> ##5 (state == ST_EMIT), "start did not reach emit in five cycles")
  `ASSERT_CLK(a_walk_phase, (state == ST_MOVE) |-> (phase == PH_R1 || phase == PH_R2), "move outside a walking phase")

endmodule

>>> sv/midpoint_ellipse_rasterizer_core.sv
// Sequencing: a start runs the setup states (squares, seed, initial decision) on the shared
//   multiplier, then pushes 4 output beats; an emitting step runs the move and update states
//   on the shared multiplier, then pushes 4 output beats; the step that enters region 2 first
//   runs the region 2 seed states; a step with nothing to emit only takes the accept. Output
//   stalls also hold the block, and no new item is taken until the last beat is loaded.
// Reset: synchronous, active high; clears sequencer, phase, walk state, valid.

module midpoint_ellipse_rasterizer_core import mer_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mer_in_if.sink     item,
  mer_out_if.source  pixel
);

  // Command and status between the sequencer and the arithmetic.
  // The sequencer owns the item handshake and the phase (idle, region 1,
  // region 2, done); the datapath owns the radii, squares, walk coordinates,
  // the 4x-scaled decision variable and the output register.
  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer: accept one item at a time, walk the datapath through the
  // multiplier schedule, then push four beats into the output register for an emitting item.
  mer_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_op    (item.op),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath: one registered multiplier shared by the setup squares, the region 1
  // test, the decision update and the region 2 seed; the output register
  // holds a beat while the consumer stalls.
  mer_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .center_x    (item.center_x),
    .center_y    (item.center_y),
    .radius_x    (item.radius_x),
    .radius_y    (item.radius_y),
    .pixel_ready (pixel.ready),
    .pixel_valid (pixel.valid),
    .pixel_x     (pixel.pixel_x),
    .pixel_y     (pixel.pixel_y),
    .last_of_run (pixel.last_of_run),
    .curve_done  (pixel.curve_done)
  );

endmodule
